>>> rtl/length_prefixed_packet_ring_buffer_assert.svh
// Assertion macros for the length-prefixed packet ring buffer.
// Included by the top level; no other dependencies.
`ifndef LENGTH_PREFIXED_PACKET_RING_BUFFER_ASSERT_SVH
`define LENGTH_PREFIXED_PACKET_RING_BUFFER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define LPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpb assertion failed");
// next-cycle implication
`define LPB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpb assertion failed");
`else
`define LPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LPB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/lpb_pkg.sv
// Shared constants for the length-prefixed packet ring buffer.
// No dependencies.
package lpb_pkg;

    // default store depth in bytes
    localparam int DEPTH_DEFAULT = 4096;

    // fixed field widths
    localparam int LEN_W  = 13;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_ACCEPTED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_REJECTED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_DELIVERED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd3;
    localparam logic [STAT_W-1:0] ST_DEST_SMALL = 3'd4;
    localparam logic [STAT_W-1:0] ST_INCOMPLETE = 3'd5;
    localparam logic [STAT_W-1:0] ST_ZERO_LEN   = 3'd6;

    // transaction kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_PULL = 1'b1;

endpackage

>>> rtl/lpb_store.sv
// Byte store of the packet ring buffer: one write port, one read port,
// registered read data. Uses lpb_pkg for the byte width.
module lpb_store #(
    parameter int DEPTH = lpb_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [lpb_pkg::BYTE_W-1:0]  wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [lpb_pkg::BYTE_W-1:0]  rd_data
);

    logic [lpb_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [lpb_pkg::BYTE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/length_prefixed_packet_ring_buffer.sv
// Length-prefixed packet ring buffer: control, pointers and result register.
// Depends on lpb_pkg, lpb_store and length_prefixed_packet_ring_buffer_assert.svh.
//
// Usage: one item channel (item_valid / item_stall) carries either a push
// of one byte (kind 0) or a pull of one packet byte (kind 1). A transaction
// completes on a rising edge with valid high and stall low. Every item gives
// exactly one result on the result channel (result_valid / result_stall).
// Pushes carry chunk_first and chunk_length on the first byte of a chunk;
// a chunk that does not fit is dropped as a whole. The first stored byte
// of a packet is its whole length, counting itself.
// The execute step registers the result and the head check loads it into the
// output register; no new item is taken before the last one is through. The
// three steps are the head byte read, the update with its store write, and
// a second read of the new head byte for packet_ready, all through the single
// store read port. A stalled result stays in the output register; the next
// item is already taken and processed, and waits only if its result cannot
// be loaded. Reset clears pointers, fill level, pull and drop state; the byte
// store needs no clearing pass, the block takes items straight after reset.
module length_prefixed_packet_ring_buffer #(
    parameter int DEPTH = lpb_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic                        kind,
    input  logic [lpb_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        chunk_first,
    input  logic [lpb_pkg::LEN_W-1:0]   chunk_length,
    input  logic [lpb_pkg::LEN_W-1:0]   dest_capacity,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [lpb_pkg::STAT_W-1:0]  status,
    output logic [lpb_pkg::BYTE_W-1:0]  out_byte,
    output logic                        out_last,
    output logic [lpb_pkg::LEN_W-1:0]   stored_bytes,
    output logic                        packet_ready
);

`include "length_prefixed_packet_ring_buffer_assert.svh"

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = ((CW > lpb_pkg::LEN_W) ? CW : lpb_pkg::LEN_W) + 1;
    localparam int BW   = lpb_pkg::BYTE_W;

    // sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_HEAD = 2'd2;

    logic [1:0]    state_reg, state_next;

    // control state
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [CW-1:0] count_reg, count_next;
    logic [BW-1:0] rem_reg, rem_next;
    logic          drop_reg, drop_next;

    // captured item
    logic                       kind_reg;
    logic [BW-1:0]              data_reg;
    logic                       first_reg;
    logic [lpb_pkg::LEN_W-1:0]  clen_reg;
    logic [lpb_pkg::LEN_W-1:0]  dcap_reg;

    // result held between execute and head check
    logic [lpb_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [BW-1:0]              res_byte_reg, res_byte_next;
    logic                       res_last_reg, res_last_next;

    // forwarding of a write to the head address
    logic          fwd_reg;
    logic [BW-1:0] fwd_data_reg;

    // output register
    logic                       out_valid_reg;
    logic [lpb_pkg::STAT_W-1:0] out_status_reg;
    logic [BW-1:0]              out_byte_reg;
    logic                       out_last_reg;
    logic [lpb_pkg::LEN_W-1:0]  out_count_reg;
    logic                       out_ready_reg;

    // store port
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [BW-1:0] rd_data;

    logic          take;
    logic          out_free;
    logic          load_out;
    logic [BW-1:0] head;
    logic          head_ready;
    logic          deliver;
    logic [BW-1:0] rem_start;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign item_stall = (state_reg != S_IDLE);
    assign take       = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !result_stall;
    assign load_out   = (state_reg == S_HEAD) && out_free;

    // head byte as seen after the execute step
    assign head = fwd_reg ? fwd_data_reg : rd_data;
    assign head_ready = (rem_reg == '0) && (count_reg != '0) && (head != '0)
                        && (CW'(head) <= count_reg);

    // execute step: push or pull against the head byte in rd_data
    always_comb
    begin
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        drop_next       = drop_reg;
        res_status_next = res_status_reg;
        res_byte_next   = res_byte_reg;
        res_last_next   = res_last_reg;
        wr_en           = 1'b0;
        deliver         = 1'b0;
        rem_start       = rem_reg;
        if (state_reg == S_EXEC)
        begin
            res_byte_next = '0;
            res_last_next = 1'b0;
            if (kind_reg == lpb_pkg::KIND_PUSH)
            begin
                if (first_reg)
                begin
                    drop_next = (count_reg >= CW'(DEPTH)) ||
                                ((SW'(count_reg) + SW'(clen_reg)) > SW'(DEPTH));
                end
                if (drop_next || (count_reg >= CW'(DEPTH)))
                begin
                    res_status_next = lpb_pkg::ST_REJECTED;
                end
                else
                begin
                    wr_en           = 1'b1;
                    wp_next         = advance(wp_reg);
                    count_next      = count_reg + 1'b1;
                    res_status_next = lpb_pkg::ST_ACCEPTED;
                end
            end
            else
            begin
                if (rem_reg == '0)
                begin
                    rem_start = rd_data;
                    if (count_reg == '0)
                        res_status_next = lpb_pkg::ST_EMPTY;
                    else if (dcap_reg < lpb_pkg::LEN_W'(rd_data))
                        res_status_next = lpb_pkg::ST_DEST_SMALL;
                    else if (count_reg < CW'(rd_data))
                        res_status_next = lpb_pkg::ST_INCOMPLETE;
                    else if (rd_data == '0)
                        res_status_next = lpb_pkg::ST_ZERO_LEN;
                    else
                        deliver = 1'b1;
                end
                else if (count_reg == '0)
                begin
                    rem_next        = '0;
                    res_status_next = lpb_pkg::ST_EMPTY;
                end
                else
                begin
                    deliver = 1'b1;
                end
                if (deliver)
                begin
                    rp_next         = advance(rp_reg);
                    count_next      = count_reg - 1'b1;
                    rem_next        = rem_start - 1'b1;
                    res_byte_next   = rd_data;
                    res_last_next   = (rem_next == '0);
                    res_status_next = lpb_pkg::ST_DELIVERED;
                end
            end
        end
    end

    // read the head: the new read pointer during execute, else the current one
    assign rd_addr = (state_reg == S_EXEC) ? rp_next : rp_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = take ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_HEAD;
            S_HEAD:  state_next = out_free ? S_IDLE : S_HEAD;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            drop_reg      <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            drop_reg  <= drop_next;
            // a write at the address read in the same cycle is forwarded once
            fwd_reg   <= wr_en && (wp_reg == rd_addr);
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= kind;
            data_reg  <= data_byte;
            first_reg <= chunk_first;
            clen_reg  <= chunk_length;
            dcap_reg  <= dest_capacity;
        end
        res_status_reg <= res_status_next;
        res_byte_reg   <= res_byte_next;
        res_last_reg   <= res_last_next;
        fwd_data_reg   <= data_reg;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_byte_reg   <= res_byte_reg;
            out_last_reg   <= res_last_reg;
            out_count_reg  <= lpb_pkg::LEN_W'(count_reg);
            out_ready_reg  <= head_ready;
        end
    end

    lpb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (data_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign out_byte     = out_byte_reg;
    assign out_last     = out_last_reg;
    assign stored_bytes = out_count_reg;
    assign packet_ready = out_ready_reg;

    // checks
    `LPB_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))
    `LPB_ASSERT_IMP(a_rem_le_count, clk, rst_n, 1'b1, CW'(rem_reg) <= count_reg)
    `LPB_ASSERT_IMP(a_ptr_meet, clk, rst_n, (count_reg == '0) || (count_reg == CW'(DEPTH)), wp_reg == rp_reg)
    `LPB_ASSERT_NXT(a_exec_head, clk, rst_n, state_reg == S_EXEC, state_reg == S_HEAD)

endmodule

>>> tb/testbench.sv
// Self-checking testbench for length_prefixed_packet_ring_buffer: push and pull
// transactions are checked against an in-bench model of the packet store.
// Depends on lpb_pkg and the length_prefixed_packet_ring_buffer top level.
`timescale 1ns / 100ps

module testbench;

    localparam int DEPTH       = lpb_pkg::DEPTH_DEFAULT;
    localparam int BYTE_W      = lpb_pkg::BYTE_W;
    localparam int LEN_W       = lpb_pkg::LEN_W;
    localparam int STAT_W      = lpb_pkg::STAT_W;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int RANDOM_OPS  = 1900;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int MAX_REPORTS = 10;

    // one transaction into the block
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data;
        logic              first;
        logic [LEN_W-1:0]  clen;
        logic [LEN_W-1:0]  dcap;
    } op_t;

    // one transaction out of the block
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] obyte;
        logic              olast;
        logic [LEN_W-1:0]  fill;
        logic              ready;
    } answer_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              item_valid    = 1'b0;
    logic              kind          = lpb_pkg::KIND_PUSH;
    logic [BYTE_W-1:0] data_byte     = '0;
    logic              chunk_first   = 1'b0;
    logic [LEN_W-1:0]  chunk_length  = '0;
    logic [LEN_W-1:0]  dest_capacity = '0;
    logic              result_stall  = 1'b0;
    logic              item_stall;
    logic              result_valid;
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
    logic [LEN_W-1:0]  stored_bytes;
    logic              packet_ready;

    // store model: copy 0 follows the block, copy 1 steers the stimulus
    logic [BYTE_W-1:0] ring      [0:1][0:DEPTH-1];
    logic [PTR_W-1:0]  wr_at     [0:1];
    logic [PTR_W-1:0]  rd_at     [0:1];
    logic [LEN_W-1:0]  held      [0:1];
    logic [7:0]        pull_left [0:1];
    logic              dropping  [0:1];

    op_t     ops_to_send [$];
    answer_t answers_due [$];
    op_t     cur_op;
    answer_t seen;
    int      total_ops    = 0;
    int      items_taken  = 0;
    int      results_seen = 0;
    int      errors       = 0;
    int      cycles       = 0;
    int      send_gap     = 0;
    int      stall_left   = 0;
    int      hold_left    = 0;
    int      holds_done   = 0;
    int      status_seen [0:7] = '{default: 0};

    length_prefixed_packet_ring_buffer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .kind          (kind),
        .data_byte     (data_byte),
        .chunk_first   (chunk_first),
        .chunk_length  (chunk_length),
        .dest_capacity (dest_capacity),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .out_byte      (out_byte),
        .out_last      (out_last),
        .stored_bytes  (stored_bytes),
        .packet_ready  (packet_ready)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    function automatic void reset_copy(input int c);
        wr_at[c]     = '0;
        rd_at[c]     = '0;
        held[c]      = '0;
        pull_left[c] = '0;
        dropping[c]  = 1'b0;
    endfunction

    // apply one transaction to a model copy and return the answer it gives
    function automatic answer_t buffer_step(input int c, input op_t o);
        answer_t           a;
        logic [BYTE_W-1:0] head;
        logic              deliver;
        a       = '0;
        deliver = 1'b0;
        head    = ring[c][rd_at[c]];
        if (o.kind == lpb_pkg::KIND_PUSH)
        begin
            // a first byte decides whether the whole chunk goes in
            if (o.first)
                dropping[c] = (held[c] >= DEPTH) || (int'(held[c]) + int'(o.clen) > DEPTH);
            if (dropping[c] || held[c] >= DEPTH)
                a.status = lpb_pkg::ST_REJECTED;
            else
            begin
                ring[c][wr_at[c]] = o.data;
                wr_at[c]          = wr_at[c] + 1'b1;
                held[c]           = held[c] + 1'b1;
                a.status          = lpb_pkg::ST_ACCEPTED;
            end
        end
        else if (pull_left[c] == 0)
        begin
            // packet start: empty, capacity, completeness, then zero length
            if (held[c] == 0)
                a.status = lpb_pkg::ST_EMPTY;
            else if (o.dcap < head)
                a.status = lpb_pkg::ST_DEST_SMALL;
            else if (held[c] < head)
                a.status = lpb_pkg::ST_INCOMPLETE;
            else if (head == 0)
                a.status = lpb_pkg::ST_ZERO_LEN;
            else
            begin
                pull_left[c] = head;
                deliver      = 1'b1;
            end
        end
        else if (held[c] == 0)
        begin
            pull_left[c] = '0;
            a.status     = lpb_pkg::ST_EMPTY;
        end
        else
            deliver = 1'b1;

        if (deliver)
        begin
            a.obyte      = ring[c][rd_at[c]];
            rd_at[c]     = rd_at[c] + 1'b1;
            held[c]      = held[c] - 1'b1;
            pull_left[c] = pull_left[c] - 1'b1;
            a.olast      = (pull_left[c] == 0);
            a.status     = lpb_pkg::ST_DELIVERED;
        end

        a.fill  = held[c];
        head    = ring[c][rd_at[c]];
        a.ready = (pull_left[c] == 0) && (held[c] != 0) && (head != 0) && (head <= held[c]);
        return a;
    endfunction

    // stimulus building, steered by model copy 1
    function automatic void queue_op(input op_t o);
        void'(buffer_step(1, o));
        ops_to_send.push_back(o);
    endfunction

    function automatic void queue_push(input logic [BYTE_W-1:0] d, input logic f,
                                       input int cl);
        op_t o;
        o.kind  = lpb_pkg::KIND_PUSH;
        o.data  = d;
        o.first = f;
        o.clen  = f ? LEN_W'(cl) : LEN_W'($urandom_range(0, DEPTH));
        o.dcap  = LEN_W'($urandom_range(0, DEPTH));
        queue_op(o);
    endfunction

    function automatic void queue_pull(input int dc);
        op_t o;
        o.kind  = lpb_pkg::KIND_PULL;
        o.data  = BYTE_W'($urandom_range(0, 255));
        o.first = 1'($urandom_range(0, 1));
        o.clen  = LEN_W'($urandom_range(0, DEPTH));
        o.dcap  = LEN_W'(dc);
        queue_op(o);
    endfunction

    function automatic int nonzero_byte();
        return $urandom_range(1, 255);
    endfunction

    // well-formed packet as one chunk; payload bytes never zero
    function automatic void queue_packet(input int len, input int cl);
        queue_push(BYTE_W'(len), 1'b1, cl);
        repeat (len - 1)
            queue_push(BYTE_W'(nonzero_byte()), 1'b0, 0);
    endfunction

    function automatic int head_len();
        return int'(ring[1][rd_at[1]]);
    endfunction

    // mostly short gaps, a few long, and quiet stretches with none
    function automatic int pick_gap();
        int roll;
        if ((cycles / 3000) % 4 == 3)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // item driver: model updated on each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid    <= 1'b0;
            kind          <= lpb_pkg::KIND_PUSH;
            data_byte     <= '0;
            chunk_first   <= 1'b0;
            chunk_length  <= '0;
            dest_capacity <= '0;
            send_gap      = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                answers_due.push_back(buffer_step(0, cur_op));
                items_taken <= items_taken + 1;
            end
            if (!item_valid || !item_stall)
            begin
                // no gaps while the receiver is held off, keep the block full
                if (send_gap > 0 && hold_left == 0)
                begin
                    send_gap   = send_gap - 1;
                    item_valid <= 1'b0;
                end
                else if (ops_to_send.size() != 0)
                begin
                    cur_op        = ops_to_send.pop_front();
                    item_valid    <= 1'b1;
                    kind          <= cur_op.kind;
                    data_byte     <= cur_op.data;
                    chunk_first   <= cur_op.first;
                    chunk_length  <= cur_op.clen;
                    dest_capacity <= cur_op.dcap;
                    send_gap      = pick_gap();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // result stall: random gaps plus two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
            stall_left   = 0;
            holds_done   = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 300 : 1200))
        begin
            holds_done   = holds_done + 1;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left   = stall_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            stall_left = pick_gap();
            if (stall_left > 0)
            begin
                stall_left   = stall_left - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // result monitor: each transaction against the oldest expected answer
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            seen         = {status, out_byte, out_last, stored_bytes, packet_ready};
            results_seen <= results_seen + 1;
            status_seen[seen.status] = status_seen[seen.status] + 1;
            if (answers_due.size() == 0)
            begin
                errors = errors + 1;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: st=%0d byte=%02h last=%0b held=%0d ready=%0b",
                             seen.status, seen.obyte, seen.olast, seen.fill, seen.ready);
            end
            else if (seen !== answers_due[0])
            begin
                errors = errors + 1;
                if (errors <= MAX_REPORTS)
                begin
                    $write("mismatch at result %0d: want st=%0d byte=%02h last=%0b",
                           results_seen, answers_due[0].status, answers_due[0].obyte,
                           answers_due[0].olast);
                    $write(" held=%0d ready=%0b,", answers_due[0].fill,
                           answers_due[0].ready);
                    $display(" got st=%0d byte=%02h last=%0b held=%0d ready=%0b",
                             seen.status, seen.obyte, seen.olast, seen.fill, seen.ready);
                end
                void'(answers_due.pop_front());
            end
            else
                void'(answers_due.pop_front());
        end
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timed out after %0d cycles, %0d results outstanding",
                 cycles, answers_due.size());
        $display("length_prefixed_packet_ring_buffer test failed");
        $finish;
    end

    initial
    begin
        int base;
        int pick;
        int len;
        int part;
        int head;

        reset_copy(0);
        reset_copy(1);

        // directed: empty store, small receiver, incomplete packet, dropped
        // chunk, pushes while a packet is being pulled, zero chunk length
        queue_pull(0);
        queue_push(8'd3, 1'b1, 3);
        queue_pull(2);
        queue_pull(DEPTH);
        queue_push(8'h00, 1'b0, 0);
        queue_push(8'hff, 1'b0, 0);
        queue_push(8'haa, 1'b1, DEPTH);
        queue_push(8'h55, 1'b0, 0);
        queue_pull(3);
        queue_push(8'd1, 1'b1, 2);
        queue_push(8'd1, 1'b0, 0);
        queue_pull(0);
        queue_pull(0);
        queue_pull(1);
        queue_pull(1);
        queue_pull(DEPTH);
        queue_push(8'd2, 1'b1, 0);
        queue_push(8'h80, 1'b0, 0);
        queue_pull(DEPTH - 1);
        queue_pull(DEPTH);

        // random: mostly whole packets pushed and pulled, some noise
        base = ops_to_send.size();
        while (ops_to_send.size() < base + RANDOM_OPS)
        begin
            pick = $urandom_range(0, 99);
            head = head_len();
            if (pull_left[1] != 0)
            begin
                if (pick < 80 || int'(held[1]) > DEPTH - 20)
                    queue_pull($urandom_range(0, DEPTH));
                else
                begin
                    len = $urandom_range(1, 12);
                    queue_packet(len, len);
                end
            end
            else if (held[1] == 0 || pick < 45)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255)
                                                  : $urandom_range(1, 12);
                if (int'(held[1]) + len <= DEPTH)
                    queue_packet(len, len);
                else
                    queue_pull(DEPTH);
            end
            else if (pick < 85)
            begin
                // start the head packet, topping it up first if it is short
                if (head <= int'(held[1]))
                    queue_pull($urandom_range(head, DEPTH));
                else
                    queue_push(BYTE_W'(nonzero_byte()), 1'b1, 1);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: queue_pull($urandom_range(0, head - 1));
                    1:
                    begin
                        // chunk too big for the room left, rest dropped too
                        queue_push(BYTE_W'($urandom_range(0, 255)), 1'b1,
                                   $urandom_range(DEPTH - int'(held[1]) + 1, DEPTH));
                        repeat ($urandom_range(0, 3))
                            queue_push(BYTE_W'($urandom_range(0, 255)), 1'b0, 0);
                    end
                    2:
                    begin
                        // packet split around a pull
                        len  = $urandom_range(2, 20);
                        part = $urandom_range(1, len - 1);
                        if (int'(held[1]) + len <= DEPTH)
                        begin
                            queue_push(BYTE_W'(len), 1'b1, len);
                            repeat (part - 1)
                                queue_push(BYTE_W'(nonzero_byte()), 1'b0, 0);
                            queue_pull($urandom_range(len, DEPTH));
                            repeat (len - part)
                                queue_push(BYTE_W'(nonzero_byte()), 1'b0, 0);
                        end
                    end
                    3: queue_push(BYTE_W'(nonzero_byte()), 1'b0, 0);
                    4: queue_pull($urandom_range(0, DEPTH));
                    default: queue_packet($urandom_range(1, 8), 0);
                endcase
            end
        end

        // drain so that a zero length byte can reach the head
        while (held[1] != 0)
        begin
            head = head_len();
            if (pull_left[1] != 0)
                queue_pull($urandom_range(0, DEPTH));
            else if (head <= int'(held[1]))
                queue_pull($urandom_range(head, DEPTH));
            else
                queue_push(BYTE_W'(nonzero_byte()), 1'b1, 1);
        end

        // zero length at the head blocks pulls for good, so it comes last
        queue_push(8'h00, 1'b1, 1);
        queue_pull($urandom_range(0, DEPTH));
        queue_pull(0);

        total_ops = ops_to_send.size();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (items_taken < total_ops || answers_due.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("run covered %0d transactions in %0d cycles, %0d long hold-offs, %0d errors",
                 total_ops, cycles, holds_done, errors);
        $display("stored %0d rejected %0d out %0d empty %0d small %0d incomplete %0d zero %0d",
                 status_seen[lpb_pkg::ST_ACCEPTED], status_seen[lpb_pkg::ST_REJECTED],
                 status_seen[lpb_pkg::ST_DELIVERED], status_seen[lpb_pkg::ST_EMPTY],
                 status_seen[lpb_pkg::ST_DEST_SMALL], status_seen[lpb_pkg::ST_INCOMPLETE],
                 status_seen[lpb_pkg::ST_ZERO_LEN]);
        if (errors == 0)
            $display("length_prefixed_packet_ring_buffer test passed");
        else
            $display("length_prefixed_packet_ring_buffer test failed");
        $finish;
    end

endmodule

>>> length_prefixed_packet_ring_buffer.f
+incdir+rtl
rtl/lpb_pkg.sv
rtl/lpb_store.sv
rtl/length_prefixed_packet_ring_buffer.sv
tb/testbench.sv
